@@ design/rcfp_pkg.sv @@
// Shared constants and types of the remote command frame parser.
package rcfp_pkg;

    // Frame markers
    localparam logic [7:0] HEAD_DRIVE    = 8'hA5;
    localparam logic [7:0] TAIL_DRIVE    = 8'h5A;
    localparam logic [7:0] HEAD_SETTINGS = 8'hB5;
    localparam logic [7:0] TAIL_SETTINGS = 8'h5B;
    localparam logic [7:0] MODE_MIX      = 8'd1;

    // Frame geometry
    localparam int WIN_LEN         = 5;
    localparam int BURST_BYTES_DEF = 64;

    // Drive arithmetic: numerator is |sum| << 14 with |sum| up to 256, divisor
    // at least 100 and at most 256
    localparam int               Q14_SHIFT = 14;
    localparam int               DEN_W     = 9;
    localparam int               NUM_W     = DEN_W + Q14_SHIFT;
    localparam int               QUO_W     = 15;
    localparam logic [DEN_W-1:0] MIN_DIV   = 9'd100;

    // Settings arithmetic
    localparam logic [11:0] SPEED_SCALE = 12'd10;

    // Register reset values
    localparam logic [6:0] DEADZONE_RST = 7'd10;
    localparam logic [7:0] LIMIT_RST    = 8'd100;

    // Register indexes
    localparam logic CFG_DEADZONE = 1'b0;
    localparam logic CFG_LIMIT    = 1'b1;

    typedef enum logic [1:0] {
        KIND_DRIVE    = 2'd0,
        KIND_AUTO     = 2'd1,
        KIND_SETTINGS = 2'd2
    } t_kind;

endpackage

@@ design/rcfp_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by both wheel channels.
module rcfp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rcfp_pkg::NUM_W-1:0]  i_num,
    input  logic [rcfp_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [rcfp_pkg::QUO_W-1:0]  o_quo
);
    import rcfp_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } t_dv_state;

    t_dv_state          r_state;
    logic [DEN_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_sh;
    logic [DEN_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               fits;

    // The quotient is known to stay below 2**QUO_W, so the top numerator bits
    // are already a valid partial remainder.
    assign trial = {r_rem, r_sh[QUO_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_rem   <= DEN_W'(i_num[NUM_W-1:QUO_W]);
                        r_sh    <= i_num[QUO_W-1:0];
                        r_den   <= i_den;
                        r_cnt   <= '0;
                        r_state <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    r_sh  <= {r_sh[QUO_W-2:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= DV_IDLE;
                    end
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sh;

endmodule

@@ design/remote_command_frame_parser_core.sv @@
// Top level of the remote command frame parser: byte window, frame check and drive mixing.
//
// Received bytes enter one per transaction on the s_axis side (tlast marks the last byte
// before line idle) and the block keeps the last five bytes of the current burst. A burst
// also closes at its BURST_BYTES-th byte. The first valid drive or settings frame of a
// burst produces one result transaction on m_axis; later frames in that burst are dropped.
// A settings frame, or a drive frame whose mode is not one, goes from the frame check through
// ST_EMIT to the output register. A mixing drive frame passes through ST_DIV_L and ST_DIV_R
// first: the wheel speeds come out of one shared restoring divider, left then right, each
// division started by a start pulse and ended by a done pulse. s_axis_tready is low while
// the divider runs and until a finished result has moved into the output register; bytes that
// produce no result keep flowing while an earlier result sits unclaimed on m_axis.
// Configuration writes are registered and are meant for idle periods only.
module remote_command_frame_parser_core #(
    parameter int BURST_BYTES = rcfp_pkg::BURST_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // burst_end
    // parsed commands
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] left_drive, [31:16] right_drive,
                                        // [43:32] run_speed, [51:44] stop_seconds, [55:52] 0
    output logic [1:0]  m_axis_tuser    // [1:0] frame_kind
);
    import rcfp_pkg::*;

    localparam int CNT_W = $clog2(BURST_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_L,
        ST_DIV_R,
        ST_EMIT
    } t_state;

    // Configuration
    logic [6:0]         r_deadzone;
    logic [7:0]         r_limit;

    // Burst tracking
    logic [7:0]         r_win [WIN_LEN];
    logic [CNT_W-1:0]   r_cnt;
    logic               r_taken;

    // Sequencer and staged result
    t_state             r_state;
    logic               r_div_start;
    logic [DEN_W-1:0]   r_l_mag;
    logic [DEN_W-1:0]   r_r_mag;
    logic               r_l_neg;
    logic               r_r_neg;
    logic [DEN_W-1:0]   r_den;
    t_kind              r_kind;
    logic [15:0]        r_left;
    logic [15:0]        r_right;
    logic [11:0]        r_speed;
    logic [7:0]         r_stop;

    // Output register
    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [15:0]        r_out_left;
    logic [15:0]        r_out_right;
    logic [11:0]        r_out_speed;
    logic [7:0]         r_out_stop;

    logic               s_acc;
    logic [7:0]         rx;
    logic               window_full;
    logic [7:0]         sum;
    logic               sum_ok;
    logic               drive_hit;
    logic               set_hit;
    logic               frame_hit;
    logic [CNT_W:0]     cnt_inc;
    logic               burst_close;

    logic [7:0]         x_mag;
    logic [7:0]         y_mag;
    logic [7:0]         x_dz;
    logic [7:0]         y_dz;
    logic signed [8:0]  l_sum;
    logic signed [8:0]  r_sum;
    logic signed [8:0]  l_neg9;
    logic signed [8:0]  r_neg9;
    logic [DEN_W-1:0]   l_mag;
    logic [DEN_W-1:0]   r_mag;
    logic [DEN_W-1:0]   big_mag;
    logic [DEN_W-1:0]   den;
    logic [7:0]         spd;
    logic [11:0]        speed_scaled;

    logic               out_free;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [NUM_W-1:0]   div_num;
    logic [15:0]        quo_pos;
    logic [15:0]        quo_neg;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Frame check against the five bytes already held
    assign window_full = r_cnt >= CNT_W'(WIN_LEN);
    assign sum         = r_win[1] + r_win[2] + r_win[3];
    assign sum_ok      = (sum == r_win[4]);
    assign drive_hit   = window_full && !r_taken && sum_ok
                         && (r_win[0] == HEAD_DRIVE) && (rx == TAIL_DRIVE);
    assign set_hit     = window_full && !r_taken && sum_ok
                         && (r_win[0] == HEAD_SETTINGS) && (rx == TAIL_SETTINGS);
    assign frame_hit   = drive_hit || set_hit;

    assign cnt_inc     = {1'b0, r_cnt} + 1'b1;
    assign burst_close = s_axis_tlast || (cnt_inc >= (CNT_W + 1)'(BURST_BYTES));

    // Deadzone and differential mix; a magnitude reaches 256 when both sticks sit at -128
    assign x_mag = r_win[1][7] ? (~r_win[1] + 8'd1) : r_win[1];
    assign y_mag = r_win[2][7] ? (~r_win[2] + 8'd1) : r_win[2];
    assign x_dz  = (x_mag < {1'b0, r_deadzone}) ? 8'd0 : r_win[1];
    assign y_dz  = (y_mag < {1'b0, r_deadzone}) ? 8'd0 : r_win[2];
    assign l_sum = {y_dz[7], y_dz} + {x_dz[7], x_dz};
    assign r_sum = {y_dz[7], y_dz} - {x_dz[7], x_dz};
    assign l_neg9 = -l_sum;
    assign r_neg9 = -r_sum;
    assign l_mag = l_sum[8] ? l_neg9[8:0] : l_sum[8:0];
    assign r_mag = r_sum[8] ? r_neg9[8:0] : r_sum[8:0];
    assign big_mag = (l_mag > r_mag) ? l_mag : r_mag;
    assign den     = (big_mag < MIN_DIV) ? MIN_DIV : big_mag;

    // Settings scaling
    assign spd          = (r_win[1] > r_limit) ? r_limit : r_win[1];
    assign speed_scaled = {4'd0, spd} * SPEED_SCALE;

    // Shared divider: left channel first, then right
    assign div_num = (r_state == ST_DIV_R) ? {r_r_mag, Q14_SHIFT'(0)}
                                           : {r_l_mag, Q14_SHIFT'(0)};

    rcfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign quo_pos = {1'b0, div_quo};
    assign quo_neg = -quo_pos;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= DEADZONE_RST;
            r_limit    <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEADZONE: r_deadzone <= i_cfg_wdata[6:0];
                CFG_LIMIT:    r_limit    <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Byte window holds every accepted byte; the count gates its use after reset
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_LEN-1] <= rx;
        end
    end

    // Burst count and first-frame flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_taken <= 1'b0;
        end else if (s_acc) begin
            if (burst_close) begin
                r_cnt   <= '0;
                r_taken <= 1'b0;
            end else begin
                r_cnt   <= cnt_inc[CNT_W-1:0];
                r_taken <= r_taken || frame_hit;
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc && drive_hit) begin
                        r_kind  <= (r_win[3] == MODE_MIX) ? KIND_DRIVE : KIND_AUTO;
                        r_left  <= '0;
                        r_right <= '0;
                        r_speed <= '0;
                        r_stop  <= '0;
                        r_l_mag <= l_mag;
                        r_r_mag <= r_mag;
                        r_l_neg <= l_sum[8];
                        r_r_neg <= r_sum[8];
                        r_den   <= den;
                        if (r_win[3] == MODE_MIX) begin
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIV_L;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end else if (s_acc && set_hit) begin
                        r_kind  <= KIND_SETTINGS;
                        r_left  <= '0;
                        r_right <= '0;
                        r_speed <= speed_scaled;
                        r_stop  <= r_win[2];
                        r_state <= ST_EMIT;
                    end
                end
                ST_DIV_L: begin
                    if (div_done) begin
                        r_left      <= r_l_neg ? quo_neg : quo_pos;
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_R;
                    end
                end
                ST_DIV_R: begin
                    if (div_done) begin
                        r_right <= r_r_neg ? quo_neg : quo_pos;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold the staged result until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        r_out_left  <= r_left;
                        r_out_right <= r_right;
                        r_out_speed <= r_speed;
                        r_out_stop  <= r_stop;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {4'd0, r_out_stop, r_out_speed, r_out_right, r_out_left};

    // A closed burst restarts the count
    a_burst_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tlast) |=> (r_cnt == '0))
        else $error("burst count not cleared after burst end");

    // Only one frame per burst: a reported frame blocks the rest of the burst
    a_frame_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && frame_hit && !burst_close) |=> r_taken)
        else $error("frame flag not set after a reported frame");

    // Divider finishes only while the sequencer waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV_L || r_state == ST_DIV_R))
        else $error("divider result with no division pending");

    // Wheel speeds are zero on every non-drive result
    a_zero_wheels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_DRIVE) |-> (r_out_left == '0 && r_out_right == '0))
        else $error("wheel speed on a non-drive result");

endmodule
